/* design/dst_pkg.sv */
`default_nettype none

package dst_pkg;

    // Default table depth.
    localparam int SLOTS_DEF = 32;

    // Field widths of the request and response beats.
    localparam int CMD_W   = 3;
    localparam int IDX_W   = 8;
    localparam int HDL_W   = 16;
    localparam int FLG_W   = 8;
    localparam int ST_W    = 2;
    localparam int RSLOT_W = 6;

    // Command codes. Code 7 has no meaning and is served by default arms.
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 3'd0,
        CMD_LOOKUP    = 3'd1,
        CMD_CLOSE     = 3'd2,
        CMD_GET_FLAGS = 3'd3,
        CMD_SET_FLAGS = 3'd4,
        CMD_CLOSE_ALL = 3'd5,
        CMD_CLOEXEC   = 3'd6
    } t_cmd;

    // Response status codes.
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADF  = 2'd3
    } t_status;

    // Source of the handle field of a response.
    typedef enum logic [1:0] {
        HS_ZERO  = 2'd0,
        HS_RDATA = 2'd1,
        HS_INPUT = 2'd2
    } t_hsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;      // capture the request beat and set the slot pointer
        logic    ptr_inc;   // step the slot pointer
        logic    rd;        // read the handle store at the pointer
        logic    alloc_wr;  // store the handle at the pointer, mark it taken
        logic    rel;       // free the slot at the pointer
        logic    set_cx;    // write the close-on-exec bit at the pointer
        logic    emit;      // load the response register
        t_status st;
        logic    slot_ptr;  // response slot is the pointer, else zero
        t_hsel   hsel;
        logic    cx_sel;    // response carries the close-on-exec bit
        logic    last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic idx_ok;    // captured index lies inside the table
        logic hdl_zero;  // captured handle is zero
        logic flag_bad;  // a flags bit above bit 0 is set
        logic occ;       // slot at the pointer is taken
        logic cx;        // close-on-exec bit at the pointer
        logic ptr_last;  // pointer is at the top slot
        logic out_free;  // response register can take a beat this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/dst_req_if.sv */
`default_nettype none

interface dst_req_if;
    logic                        valid;
    logic                        ready;
    logic [dst_pkg::CMD_W-1:0]   cmd;
    logic signed [dst_pkg::IDX_W-1:0] slot_index;
    logic [dst_pkg::HDL_W-1:0]   handle;
    logic [dst_pkg::FLG_W-1:0]   flags_value;

    modport source (output valid, output cmd, output slot_index, output handle,
                    output flags_value, input ready);
    modport sink (input valid, input cmd, input slot_index, input handle,
                  input flags_value, output ready);
endinterface

`default_nettype wire

/* design/dst_rsp_if.sv */
`default_nettype none

interface dst_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [dst_pkg::ST_W-1:0]    status;
    logic [dst_pkg::RSLOT_W-1:0] result_slot;
    logic [dst_pkg::HDL_W-1:0]   result_handle;
    logic                        cloexec_out;
    logic                        last;

    modport source (output valid, output status, output result_slot,
                    output result_handle, output cloexec_out, output last,
                    input ready);
    modport sink (input valid, input status, input result_slot,
                  input result_handle, input cloexec_out, input last,
                  output ready);
endinterface

`default_nettype wire

/* design/dst_dpath.sv */
`default_nettype none

module dst_dpath #(
    parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire dst_pkg::t_dp_cmd               i_ctl,
    output      dst_pkg::t_dp_stat              o_stat,
    input  wire logic [dst_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic signed [dst_pkg::IDX_W-1:0] i_slot_index,
    input  wire logic [dst_pkg::HDL_W-1:0]      i_handle,
    input  wire logic [dst_pkg::FLG_W-1:0]      i_flags_value,
    input  wire logic                           i_out_ready,
    output      logic                           o_out_valid,
    output      logic [dst_pkg::ST_W-1:0]       o_status,
    output      logic [dst_pkg::RSLOT_W-1:0]    o_result_slot,
    output      logic [dst_pkg::HDL_W-1:0]      o_result_handle,
    output      logic                           o_cloexec_out,
    output      logic                           o_last
);

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    dst_pkg::t_cmd                       r_cmd;
    logic signed [dst_pkg::IDX_W-1:0]    r_idx;
    logic [dst_pkg::HDL_W-1:0]           r_handle;
    logic [dst_pkg::FLG_W-1:0]           r_flags;
    logic [PW-1:0]                       r_ptr;
    logic [SLOTS-1:0]                    r_occ;
    logic [SLOTS-1:0]                    r_cx;
    logic [dst_pkg::HDL_W-1:0]           r_mem [SLOTS];
    logic [dst_pkg::HDL_W-1:0]           r_rdata;

    logic                                r_ovalid;
    dst_pkg::t_status                    r_ost;
    logic [dst_pkg::RSLOT_W-1:0]         r_oslot;
    logic [dst_pkg::HDL_W-1:0]           r_ohdl;
    logic                                r_ocx;
    logic                                r_olast;

    logic                                w_sweep_in;
    logic [dst_pkg::HDL_W-1:0]           w_hdl;

    assign w_sweep_in = (dst_pkg::t_cmd'(i_cmd) == dst_pkg::CMD_CLOSE_ALL) ||
                        (dst_pkg::t_cmd'(i_cmd) == dst_pkg::CMD_CLOEXEC);

    // Captured request and slot pointer. Sweeps start at slot zero; every
    // other command points at its index (the low bits are only used once the
    // index has been checked).
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= dst_pkg::t_cmd'(i_cmd);
            r_idx    <= i_slot_index;
            r_handle <= i_handle;
            r_flags  <= i_flags_value;
        end
        if (i_ctl.load) begin
            r_ptr <= w_sweep_in ? '0 : i_slot_index[PW-1:0];
        end else if (i_ctl.ptr_inc) begin
            r_ptr <= r_ptr + PW'(1);
        end
    end

    // Taken and close-on-exec bits per slot; a slot that is not taken is never
    // read by the controller, so the handle store itself needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_cx  <= '0;
        end else begin
            if (i_ctl.alloc_wr) begin
                r_occ[r_ptr] <= 1'b1;
                r_cx[r_ptr]  <= 1'b0;
            end else if (i_ctl.rel) begin
                r_occ[r_ptr] <= 1'b0;
                r_cx[r_ptr]  <= 1'b0;
            end else if (i_ctl.set_cx) begin
                r_cx[r_ptr]  <= r_flags[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc_wr) begin
            r_mem[r_ptr] <= r_handle;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_comb begin
        case (i_ctl.hsel)
            dst_pkg::HS_RDATA: w_hdl = r_rdata;
            dst_pkg::HS_INPUT: w_hdl = r_handle;
            default:           w_hdl = '0;
        endcase
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_ost   <= i_ctl.st;
            r_oslot <= i_ctl.slot_ptr ? dst_pkg::RSLOT_W'(r_ptr) : '0;
            r_ohdl  <= w_hdl;
            r_ocx   <= i_ctl.cx_sel & r_cx[r_ptr];
            r_olast <= i_ctl.last;
        end
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.idx_ok   = !r_idx[dst_pkg::IDX_W-1] &&
                          (r_idx[dst_pkg::IDX_W-2:0] < (dst_pkg::IDX_W-1)'(SLOTS));
        o_stat.hdl_zero = (r_handle == '0);
        o_stat.flag_bad = |r_flags[dst_pkg::FLG_W-1:1];
        o_stat.occ      = r_occ[r_ptr];
        o_stat.cx       = r_cx[r_ptr];
        o_stat.ptr_last = (r_ptr == PW'(SLOTS - 1));
        o_stat.out_free = !r_ovalid || i_out_ready;
    end

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ost;
    assign o_result_slot   = r_oslot;
    assign o_result_handle = r_ohdl;
    assign o_cloexec_out   = r_ocx;
    assign o_last          = r_olast;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit |-> (!r_ovalid || i_out_ready))
        else $error("response loaded over a beat not yet taken");

    a_alloc_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.alloc_wr |=> (r_occ[r_ptr] && !r_cx[r_ptr]))
        else $error("allocated slot not marked taken with close-on-exec clear");

    a_rel_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.rel |=> !r_occ[r_ptr])
        else $error("released slot still marked taken");

endmodule

`default_nettype wire

/* design/dst_ctrl.sv */
`default_nettype none

module dst_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire dst_pkg::t_dp_stat  i_stat,
    output      dst_pkg::t_dp_cmd   o_ctl
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_DECODE  = 6'b000010,
        S_ALLOC   = 6'b000100,
        S_LOOK    = 6'b001000,
        S_SWEEP   = 6'b010000,
        S_RELEASE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_slot_ok;
    logic   w_match;

    function automatic dst_pkg::t_dp_cmd f_emit(dst_pkg::t_status st, logic slot_ptr,
                                                dst_pkg::t_hsel hsel, logic cx_sel,
                                                logic last);
        dst_pkg::t_dp_cmd c;
        c          = '0;
        c.emit     = 1'b1;
        c.st       = st;
        c.slot_ptr = slot_ptr;
        c.hsel     = hsel;
        c.cx_sel   = cx_sel;
        c.last     = last;
        return c;
    endfunction

    assign w_slot_ok = i_stat.idx_ok && i_stat.occ;
    assign w_match   = i_stat.occ &&
                       ((i_stat.cmd == dst_pkg::CMD_CLOSE_ALL) || i_stat.cx);

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    dst_pkg::CMD_ALLOC: begin
                        if (!i_stat.idx_ok || i_stat.hdl_zero) begin
                            if (i_stat.out_free) begin
                                o_ctl   = f_emit(dst_pkg::ST_INVAL, 1'b0,
                                                 dst_pkg::HS_ZERO, 1'b0, 1'b1);
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    dst_pkg::CMD_LOOKUP, dst_pkg::CMD_CLOSE: begin
                        if (w_slot_ok) begin
                            o_ctl.rd = 1'b1;
                            n_state  = S_LOOK;
                        end else if (i_stat.out_free) begin
                            o_ctl   = f_emit(dst_pkg::ST_BADF, 1'b0,
                                             dst_pkg::HS_ZERO, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                    dst_pkg::CMD_GET_FLAGS: begin
                        if (i_stat.out_free) begin
                            if (w_slot_ok) begin
                                o_ctl = f_emit(dst_pkg::ST_OK, 1'b1,
                                               dst_pkg::HS_ZERO, 1'b1, 1'b1);
                            end else begin
                                o_ctl = f_emit(dst_pkg::ST_BADF, 1'b0,
                                               dst_pkg::HS_ZERO, 1'b0, 1'b1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    dst_pkg::CMD_SET_FLAGS: begin
                        if (i_stat.out_free) begin
                            if (i_stat.flag_bad) begin
                                o_ctl = f_emit(dst_pkg::ST_INVAL, 1'b0,
                                               dst_pkg::HS_ZERO, 1'b0, 1'b1);
                            end else if (!w_slot_ok) begin
                                o_ctl = f_emit(dst_pkg::ST_BADF, 1'b0,
                                               dst_pkg::HS_ZERO, 1'b0, 1'b1);
                            end else begin
                                o_ctl        = f_emit(dst_pkg::ST_OK, 1'b1,
                                                      dst_pkg::HS_ZERO, 1'b0, 1'b1);
                                o_ctl.set_cx = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    dst_pkg::CMD_CLOSE_ALL, dst_pkg::CMD_CLOEXEC: begin
                        n_state = S_SWEEP;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_ctl   = f_emit(dst_pkg::ST_INVAL, 1'b0,
                                             dst_pkg::HS_ZERO, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_ALLOC: begin
                if (!i_stat.occ) begin
                    if (i_stat.out_free) begin
                        o_ctl          = f_emit(dst_pkg::ST_OK, 1'b1,
                                                dst_pkg::HS_INPUT, 1'b0, 1'b1);
                        o_ctl.alloc_wr = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_stat.ptr_last) begin
                    if (i_stat.out_free) begin
                        o_ctl   = f_emit(dst_pkg::ST_FULL, 1'b0,
                                         dst_pkg::HS_ZERO, 1'b0, 1'b1);
                        n_state = S_IDLE;
                    end
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            S_LOOK: begin
                if (i_stat.out_free) begin
                    o_ctl     = f_emit(dst_pkg::ST_OK, 1'b1,
                                       dst_pkg::HS_RDATA, 1'b0, 1'b1);
                    o_ctl.rel = (i_stat.cmd == dst_pkg::CMD_CLOSE);
                    n_state   = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (w_match) begin
                    o_ctl.rd = 1'b1;
                    n_state  = S_RELEASE;
                end else if (i_stat.ptr_last) begin
                    if (i_stat.out_free) begin
                        o_ctl   = f_emit(dst_pkg::ST_OK, 1'b0,
                                         dst_pkg::HS_ZERO, 1'b0, 1'b1);
                        n_state = S_IDLE;
                    end
                end else begin
                    o_ctl.ptr_inc = 1'b1;
                end
            end
            S_RELEASE: begin
                // The slot is freed here, so the sweep state sees it free on
                // return and moves on or finishes.
                if (i_stat.out_free) begin
                    o_ctl     = f_emit(dst_pkg::ST_OK, 1'b1,
                                       dst_pkg::HS_RDATA, 1'b0, 1'b0);
                    o_ctl.rel = 1'b1;
                    n_state   = S_SWEEP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.emit && o_ctl.last) |=> (r_state == S_IDLE))
        else $error("command did not end after its final beat");

    a_load_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    a_release_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RELEASE) && ($past(r_state) != S_RELEASE)) |-> $past(o_ctl.rd))
        else $error("release entered without a handle read");

endmodule

`default_nettype wire

/* design/descriptor_slot_table.sv */
`default_nettype none

// Channel   Dir  Modport  Beat contents
// i_req     in   sink     cmd, slot_index, handle, flags_value
// o_rsp     out  source   status, result_slot, result_handle, cloexec_out, last
//
// One request is worked on at a time. Get flags and set flags are answered
// from the decode state, lookup and close of a taken slot read the handle store
// first, and allocate walks up from the start index past each taken slot. The
// sweeps walk the table one slot per cycle, except where a slot is released or
// the response stalls, through a single handle-store read port. Reset is
// synchronous and active low; it frees every slot at once through the per-slot
// taken bits. The response register lets the next request be accepted while the
// final beat still waits, and a stalled response simply holds the controller in its current state.

module descriptor_slot_table #(
    parameter int SLOTS = dst_pkg::SLOTS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dst_req_if.sink    i_req,
    dst_rsp_if.source  o_rsp
);

    dst_pkg::t_dp_cmd  w_ctl;
    dst_pkg::t_dp_stat w_stat;
    logic              w_in_ready;

    // The controller sequences each command; the datapath holds the table,
    // the slot pointer and the response register.
    dst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    dst_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .i_cmd           (i_req.cmd),
        .i_slot_index    (i_req.slot_index),
        .i_handle        (i_req.handle),
        .i_flags_value   (i_req.flags_value),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_result_slot   (o_rsp.result_slot),
        .o_result_handle (o_rsp.result_handle),
        .o_cloexec_out   (o_rsp.cloexec_out),
        .o_last          (o_rsp.last)
    );

    // Requests are taken only while the controller is idle.
    assign i_req.ready = w_in_ready;

endmodule

`default_nettype wire

/* test/descriptor_slot_table_tb.sv */
`timescale 1ns / 100ps

module descriptor_slot_table_tb;
    import dst_pkg::*;

    localparam int SLOTS = SLOTS_DEF;

    // Command code 7 has no enum member; the block must answer it with invalid argument.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // A sweep can release every slot, and each release lengthens it.
    // This is the number of quiet cycles allowed after the last expected beat.
    localparam int SETTLE_CYCLES = 4 * SLOTS + 40;

    // One request beat as the predictor sees it. The index is kept as raw bits
    // and sign-extended where it is used.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   idx;
        logic [HDL_W-1:0]   hdl;
        logic [FLG_W-1:0]   flags;
    } slot_req_t;

    typedef struct packed {
        t_status            status;
        logic [RSLOT_W-1:0] slot;
        logic [HDL_W-1:0]   hdl;
        logic               cx;
        logic               last;
    } slot_rsp_t;

    // A row of the directed table. Where known is set, rsp is the answer typed
    // in by hand and is checked in place of the predicted one.
    typedef struct packed {
        slot_req_t req;
        logic      known;
        slot_rsp_t rsp;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Fresh table: nothing to look up, and close-all gives only its final beat.
        '{'{CMD_LOOKUP,    8'd0,   16'h0000, 8'h00}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_CLOSE_ALL, 8'd0,   16'h0000, 8'h00}, 1'b1, '{ST_OK,    6'd0,  16'h0000, 1'b0, 1'b1}},
        // Allocation start out of range at both ends, then a zero handle.
        '{'{CMD_ALLOC,     8'h80,  16'h0005, 8'h00}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'd32,  16'h0005, 8'h00}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'h7F,  16'h0005, 8'h00}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'd0,   16'h0000, 8'h00}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        // Bottom and top slots, then a start at the top with nothing free above it.
        '{'{CMD_ALLOC,     8'd0,   16'hFFFF, 8'h00}, 1'b1, '{ST_OK,    6'd0,  16'hFFFF, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'd31,  16'h0001, 8'h00}, 1'b1, '{ST_OK,    6'd31, 16'h0001, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'd31,  16'h0002, 8'h00}, 1'b1, '{ST_FULL,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_ALLOC,     8'd0,   16'h1234, 8'h00}, 1'b0, '0},
        '{'{CMD_ALLOC,     8'd1,   16'h8001, 8'h00}, 1'b0, '0},
        '{'{CMD_LOOKUP,    8'd0,   16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_LOOKUP,    8'hFF,  16'hFFFF, 8'hFF}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_LOOKUP,    8'd32,  16'h0000, 8'h00}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_GET_FLAGS, 8'd0,   16'h0000, 8'h00}, 1'b0, '0},
        // Flags are checked before the index, so a good slot still fails here.
        '{'{CMD_SET_FLAGS, 8'd0,   16'h0000, 8'hFF}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_SET_FLAGS, 8'h80,  16'h0000, 8'h01}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_SET_FLAGS, 8'd5,   16'h0000, 8'h01}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_SET_FLAGS, 8'd0,   16'h0000, 8'h01}, 1'b0, '0},
        '{'{CMD_SET_FLAGS, 8'd31,  16'h0000, 8'h01}, 1'b0, '0},
        '{'{CMD_GET_FLAGS, 8'd31,  16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_CLOSE,     8'd5,   16'h0000, 8'h00}, 1'b1, '{ST_BADF,  6'd0,  16'h0000, 1'b0, 1'b1}},
        '{'{CMD_UNUSED,    8'h55,  16'hAAAA, 8'hAA}, 1'b1, '{ST_INVAL, 6'd0,  16'h0000, 1'b0, 1'b1}},
        // Close-on-exec must release slots 0 and 31 and leave 1 and 2 alone.
        '{'{CMD_CLOEXEC,   8'd0,   16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_CLOSE,     8'd1,   16'h0000, 8'h00}, 1'b0, '0},
        '{'{CMD_CLOSE_ALL, 8'd0,   16'h0000, 8'h00}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    dst_req_if req_if ();
    dst_rsp_if rsp_if ();

    descriptor_slot_table #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the descriptor table, advanced at every accepted request beat.
    logic [HDL_W-1:0] shadow_hdl [SLOTS];
    logic             shadow_cx  [SLOTS];

    // Response beats still owed by the block, oldest first.
    slot_rsp_t pending_replies [$];

    int error_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Applies one command to the shadow table and returns the beats it should produce.
    function automatic void apply_to_table(input slot_req_t r, output slot_rsp_t beats [$]);
        int        idx_i;
        bit        in_range;
        bit        occ;
        bit        found;
        slot_rsp_t one;
        slot_rsp_t rel;
        beats    = {};
        idx_i    = $signed(r.idx);
        in_range = idx_i >= 0 && idx_i < SLOTS;
        occ      = 1'b0;
        if (in_range) begin
            occ = shadow_hdl[idx_i] != '0;
        end
        one        = '0;
        one.status = ST_OK;
        one.last   = 1'b1;
        case (r.cmd)
            CMD_ALLOC: begin
                if (!in_range || r.hdl == '0) begin
                    one.status = ST_INVAL;
                end else begin
                    found = 1'b0;
                    for (int i = idx_i; i < SLOTS && !found; i++) begin
                        if (shadow_hdl[i] == '0) begin
                            found         = 1'b1;
                            shadow_hdl[i] = r.hdl;
                            shadow_cx[i]  = 1'b0;
                            one.slot      = RSLOT_W'(i);
                            one.hdl       = r.hdl;
                        end
                    end
                    if (!found) begin
                        one.status = ST_FULL;
                    end
                end
            end
            CMD_LOOKUP, CMD_CLOSE, CMD_GET_FLAGS: begin
                if (!occ) begin
                    one.status = ST_BADF;
                end else begin
                    one.slot = RSLOT_W'(idx_i);
                    if (r.cmd == CMD_GET_FLAGS) begin
                        one.cx = shadow_cx[idx_i];
                    end else begin
                        one.hdl = shadow_hdl[idx_i];
                    end
                    if (r.cmd == CMD_CLOSE) begin
                        shadow_hdl[idx_i] = '0;
                        shadow_cx[idx_i]  = 1'b0;
                    end
                end
            end
            CMD_SET_FLAGS: begin
                if (r.flags[FLG_W-1:1] != '0) begin
                    one.status = ST_INVAL;
                end else if (!occ) begin
                    one.status = ST_BADF;
                end else begin
                    shadow_cx[idx_i] = r.flags[0];
                    one.slot         = RSLOT_W'(idx_i);
                end
            end
            CMD_CLOSE_ALL, CMD_CLOEXEC: begin
                // One beat per released handle in ascending slot order; the
                // closing beat below then carries only the last mark.
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_hdl[i] != '0 && (r.cmd == CMD_CLOSE_ALL || shadow_cx[i])) begin
                        rel        = '0;
                        rel.status = ST_OK;
                        rel.slot   = RSLOT_W'(i);
                        rel.hdl    = shadow_hdl[i];
                        beats.push_back(rel);
                        shadow_hdl[i] = '0;
                        shadow_cx[i]  = 1'b0;
                    end
                end
            end
            default: begin
                one.status = ST_INVAL;
            end
        endcase
        beats.push_back(one);
    endfunction

    // Random command, mostly well formed: single-slot commands usually name a
    // slot that is in use, and flag writes usually touch bit 0 only. The rest
    // is out-of-range indexes, zero handles, bad flags and unused codes.
    function automatic slot_req_t random_command();
        slot_req_t r;
        int        pick;
        int        busy [$];
        r.cmd   = CMD_LOOKUP;
        r.idx   = IDX_W'($urandom);
        r.hdl   = HDL_W'($urandom);
        r.flags = FLG_W'($urandom);
        pick    = $urandom_range(99);
        for (int i = 0; i < SLOTS; i++) begin
            if (shadow_hdl[i] != '0) begin
                busy.push_back(i);
            end
        end
        if (pick < 35) begin
            r.cmd = CMD_ALLOC;
            if ($urandom_range(9) < 8) begin
                r.idx = IDX_W'($urandom_range(0, SLOTS - 1));
            end
            if ($urandom_range(9) == 0) begin
                r.hdl = '0;
            end else if (r.hdl == '0) begin
                r.hdl = HDL_W'(1);
            end
        end else if (pick < 80) begin
            if (pick < 48) begin
                r.cmd = CMD_LOOKUP;
            end else if (pick < 58) begin
                r.cmd = CMD_CLOSE;
            end else if (pick < 68) begin
                r.cmd = CMD_GET_FLAGS;
            end else begin
                r.cmd = CMD_SET_FLAGS;
                if ($urandom_range(4) != 0) begin
                    r.flags = {{(FLG_W-1){1'b0}}, r.flags[0]};
                end
            end
            if (busy.size() != 0 && $urandom_range(3) != 0) begin
                r.idx = IDX_W'(busy[$urandom_range(0, busy.size() - 1)]);
            end else if ($urandom_range(1) == 0) begin
                r.idx = IDX_W'($urandom_range(0, SLOTS - 1));
            end
        end else if (pick < 85) begin
            r.cmd = CMD_CLOSE_ALL;
        end else if (pick < 92) begin
            r.cmd = CMD_CLOEXEC;
        end else if (pick < 96) begin
            r.cmd = CMD_UNUSED;
        end else begin
            r.cmd = CMD_W'($urandom);
        end
        return r;
    endfunction

    // Offers one request beat after a random idle gap and, once it is taken,
    // books the beats it owes. A row with a typed answer books that instead.
    task automatic send_command(input slot_req_t r, input bit known, input slot_rsp_t known_rsp);
        slot_rsp_t beats [$];
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= r.cmd;
        req_if.slot_index  <= r.idx;
        req_if.handle      <= r.hdl;
        req_if.flags_value <= r.flags;
        @(posedge clk);
        while (!req_if.ready) begin
            @(posedge clk);
        end
        apply_to_table(r, beats);
        if (known) begin
            pending_replies.push_back(known_rsp);
        end else begin
            foreach (beats[i]) begin
                pending_replies.push_back(beats[i]);
            end
        end
    endtask

    // Stops offering requests and waits until every owed beat has come back.
    task automatic drain_replies();
        req_if.valid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Response side: check each accepted beat, then pick ready for the next
    // cycle. A long hold-off set by the stimulus is counted down here.
    initial begin
        slot_rsp_t want;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("response beat with nothing expected");
                end else begin
                    want = pending_replies.pop_front();
                    if (rsp_if.status != want.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  rsp_if.status, want.status));
                    end
                    if (rsp_if.result_slot != want.slot) begin
                        report_mismatch($sformatf("result_slot got %0d expected %0d",
                                                  rsp_if.result_slot, want.slot));
                    end
                    if (rsp_if.result_handle != want.hdl) begin
                        report_mismatch($sformatf("result_handle got %h expected %h",
                                                  rsp_if.result_handle, want.hdl));
                    end
                    if (rsp_if.cloexec_out != want.cx) begin
                        report_mismatch($sformatf("cloexec_out got %0d expected %0d",
                                                  rsp_if.cloexec_out, want.cx));
                    end
                    if (rsp_if.last != want.last) begin
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  rsp_if.last, want.last));
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= CMD_LOOKUP;
        req_if.slot_index  <= '0;
        req_if.handle      <= '0;
        req_if.flags_value <= '0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_hdl[i] = '0;
            shadow_cx[i]  = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly while the receiver stalls most of the time.
        send_idle_pct = 23;
        recv_idle_pct = 76;
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_command(DIRECTED[i].req, DIRECTED[i].known, DIRECTED[i].rsp);
        end

        // The receiver goes deaf for a long stretch while requests keep coming,
        // so the response register fills and the request side must back up.
        hold_cycles = 250;
        repeat (20) send_command(random_command(), 1'b0, '0);
        drain_replies();

        send_idle_pct = 76;
        recv_idle_pct = 23;
        repeat (20) send_command(random_command(), 1'b0, '0);
        drain_replies();

        // Back to back in both directions: fill the table until allocation
        // reports it full, mark some slots, then free running random traffic.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (SLOTS + 2) begin
            send_command('{CMD_ALLOC, IDX_W'($urandom_range(0, 3)),
                           HDL_W'($urandom_range(1, 65535)), 8'h00}, 1'b0, '0);
        end
        repeat (6) begin
            send_command('{CMD_SET_FLAGS, IDX_W'($urandom_range(0, SLOTS - 1)),
                           16'h0000, 8'h01}, 1'b0, '0);
        end
        repeat (6) send_command(random_command(), 1'b0, '0);
        drain_replies();

        // Anything the block still sends now is an unexpected beat.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a hung handshake must not keep the run going forever.
    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

/* descriptor_slot_table.f */
design/dst_pkg.sv
design/dst_req_if.sv
design/dst_rsp_if.sv
design/dst_dpath.sv
design/dst_ctrl.sv
design/descriptor_slot_table.sv
test/descriptor_slot_table_tb.sv
